/* src/bba_pkg.sv */
package bba_pkg;

   localparam int MAX_BLOCKS         = 32768;
   localparam int BITS_PER_MAP_BLOCK = 32768;
   localparam int WORD_BITS          = 32;
   localparam int MAP_WORDS          = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W             = $clog2(MAP_WORDS);
   localparam int BIT_W              = $clog2(WORD_BITS);
   localparam int BLK_W              = 15;
   localparam int CNT_W              = 16;
   localparam int RESERVED_BASE      = 3;

   localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RESET = 16'd32768;

   localparam logic [1:0] FUNC_QUERY = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_ALLOC = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_FREE_ZERO = 2'd2;
   localparam logic [1:0] STATUS_RANGE     = 2'd3;

   typedef struct packed {
      logic       clear_step;
      logic       accept;
      logic       rd_op;
      logic       free_wr;
      logic       div_load;
      logic       div_step;
      logic       setup;
      logic       setup_phase2;
      logic       scan_step;
      logic       commit;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_query;
      logic       rsp_alloc;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [1:0] func;
      logic       blk_zero;
      logic       blk_oor;
      logic       has_space;
      logic       div_done;
      logic       start_zero;
      logic       found;
      logic       phase_done;
   } sts_type;

endpackage

/* src/bba_ctrl.sv */
module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bba_pkg::sts_type sts,
   output bba_pkg::cmd_type cmd
);
   import bba_pkg::*;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_DISPATCH = 4'd2;
   localparam logic [3:0] ST_READ     = 4'd3;
   localparam logic [3:0] ST_CHECK    = 4'd4;
   localparam logic [3:0] ST_DIV      = 4'd5;
   localparam logic [3:0] ST_SETUP1   = 4'd6;
   localparam logic [3:0] ST_SCAN1    = 4'd7;
   localparam logic [3:0] ST_SETUP2   = 4'd8;
   localparam logic [3:0] ST_SCAN2    = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.func)
               FUNC_QUERY: begin
                  if (sts.blk_oor) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_RANGE;
                     state_in       = ST_IDLE;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               FUNC_FREE: begin
                  if (sts.blk_zero) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_FREE_ZERO;
                     state_in       = ST_IDLE;
                  end else if (sts.blk_oor) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_RANGE;
                     state_in       = ST_IDLE;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               FUNC_ALLOC: begin
                  if (!sts.has_space) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_NO_SPACE;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.div_load = 1'b1;
                     state_in     = ST_DIV;
                  end
               end
               default: begin
                  // unused op code: all-zero result
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = STATUS_OK;
                  state_in       = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            cmd.rd_op = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.free_wr    = (sts.func == FUNC_FREE);
            cmd.rsp_query  = (sts.func == FUNC_QUERY);
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = STATUS_OK;
            state_in       = ST_IDLE;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_SETUP1;
            else cmd.div_step = 1'b1;
         end
         ST_SETUP1: begin
            cmd.setup = 1'b1;
            state_in  = ST_SCAN1;
         end
         ST_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (sts.found) begin
               cmd.commit     = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STATUS_OK;
               cmd.rsp_alloc  = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.phase_done) begin
               if (sts.start_zero) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = STATUS_NO_SPACE;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_SETUP2;
               end
            end
         end
         ST_SETUP2: begin
            cmd.setup        = 1'b1;
            cmd.setup_phase2 = 1'b1;
            state_in         = ST_SCAN2;
         end
         ST_SCAN2: begin
            cmd.scan_step = 1'b1;
            if (sts.found) begin
               cmd.commit     = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STATUS_OK;
               cmd.rsp_alloc  = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.phase_done) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STATUS_NO_SPACE;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

/* src/bba_dp.sv */
module bba_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_func,
   input  logic [bba_pkg::BLK_W-1:0] req_block_number,
   input  logic                     csr_wr_en,
   input  logic [bba_pkg::CNT_W-1:0] csr_wr_data,
   input  bba_pkg::cmd_type         cmd,
   output bba_pkg::sts_type         sts,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [bba_pkg::BLK_W-1:0] rsp_result_block,
   output logic                     rsp_is_free
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   logic [CNT_W-1:0]     total_blocks_ff;
   logic [BLK_W-1:0]     search_start_ff;
   logic [1:0]           func_ff;
   logic [BLK_W-1:0]     blk_ff;
   logic [ADDR_W-1:0]    clr_addr_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic [ADDR_W-1:0]    rword_ff;
   logic                 rd_valid_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    last_ff;
   logic [BIT_W-1:0]     last_bit_ff;
   logic [CNT_W-1:0]     lo_ff;
   logic [BLK_W-1:0]     rem_ff;
   logic [BLK_W-1:0]     dividend_ff;
   logic [3:0]           div_cnt_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [BLK_W-1:0]     rsp_result_ff;
   logic                 rsp_is_free_ff;

   logic [CNT_W-1:0]     n_blocks;
   logic [CNT_W-1:0]     reserved;
   logic [CNT_W-1:0]     usable;
   logic [CNT_W-1:0]     start_sum;
   logic [CNT_W-1:0]     div_trial;
   logic [CNT_W-1:0]     lo_sel;
   logic [CNT_W-1:0]     hi_sel;
   logic [CNT_W-1:0]     hi_m1;
   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] hi_mask;
   logic [WORD_BITS-1:0] masked;
   logic [BIT_W-1:0]     bit_idx;
   logic [BLK_W-1:0]     found_blk;
   logic [CNT_W-1:0]     found_off;
   logic [WORD_BITS-1:0] blk_onehot;
   logic [WORD_BITS-1:0] hit_onehot;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;

   // effective block count and reserved head region
   assign n_blocks  = (total_blocks_ff < CNT_W'(MAX_BLOCKS)) ? total_blocks_ff
                                                             : CNT_W'(MAX_BLOCKS);
   assign reserved  = CNT_W'(n_blocks / BITS_PER_MAP_BLOCK) + CNT_W'(RESERVED_BASE);
   assign usable    = n_blocks - reserved;
   assign start_sum = reserved + {1'b0, rem_ff};

   // one restoring step of search_start % usable per cycle
   assign div_trial = {rem_ff, dividend_ff[BLK_W-1]};

   assign lo_sel = cmd.setup_phase2 ? reserved : start_sum;
   assign hi_sel = cmd.setup_phase2 ? start_sum : n_blocks;
   assign hi_m1  = hi_sel - 16'd1;

   assign lo_mask = (rword_ff == lo_ff[BIT_W +: ADDR_W]) ? ('1 << lo_ff[BIT_W-1:0]) : '1;
   assign hi_mask = (rword_ff == last_ff) ? ('1 >> (BIT_W'(WORD_BITS - 1) - last_bit_ff))
                                          : '1;
   assign masked  = rdata_ff & lo_mask & hi_mask;

   always_comb begin
      bit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (masked[i]) bit_idx = BIT_W'(i);
      end
   end

   assign found_blk  = {rword_ff, bit_idx};
   assign found_off  = {1'b0, found_blk} - reserved;
   assign hit_onehot = WORD_BITS'(1) << bit_idx;
   assign blk_onehot = WORD_BITS'(1) << blk_ff[BIT_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = blk_ff[BIT_W +: ADDR_W];
      wr_data = rdata_ff | blk_onehot;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.free_wr) begin
         wr_en = 1'b1;
      end else if (cmd.commit) begin
         wr_en   = 1'b1;
         wr_addr = rword_ff;
         wr_data = rdata_ff & ~hit_onehot;
      end
   end

   assign rd_en   = cmd.rd_op | cmd.scan_step;
   assign rd_addr = cmd.rd_op ? blk_ff[BIT_W +: ADDR_W] : addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_blocks_ff <= TOTAL_BLOCKS_RESET;
         search_start_ff <= '0;
         clr_addr_ff     <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) total_blocks_ff <= csr_wr_data;
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (cmd.commit) search_start_ff <= found_off[BLK_W-1:0];
         if (cmd.setup) rd_valid_ff <= 1'b0;
         else if (cmd.scan_step) rd_valid_ff <= 1'b1;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         blk_ff  <= req_block_number;
      end
      if (cmd.div_load) begin
         rem_ff      <= '0;
         dividend_ff <= search_start_ff;
         div_cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff      <= (div_trial >= usable) ? BLK_W'(div_trial - usable)
                                              : div_trial[BLK_W-1:0];
         dividend_ff <= dividend_ff << 1;
         div_cnt_ff  <= div_cnt_ff + 1'b1;
      end
      if (cmd.setup) begin
         lo_ff       <= lo_sel;
         addr_ff     <= lo_sel[BIT_W +: ADDR_W];
         last_ff     <= hi_m1[BIT_W +: ADDR_W];
         last_bit_ff <= hi_m1[BIT_W-1:0];
      end else if (cmd.scan_step) begin
         rword_ff <= addr_ff;
         if (addr_ff != last_ff) addr_ff <= addr_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_is_free_ff <= cmd.rsp_query & rdata_ff[blk_ff[BIT_W-1:0]];
         rsp_result_ff  <= cmd.rsp_alloc ? found_blk : '0;
      end
   end

   always_comb begin
      sts            = '0;
      sts.clear_done = (clr_addr_ff == ADDR_W'(MAP_WORDS - 1));
      sts.func       = func_ff;
      sts.blk_zero   = (blk_ff == '0);
      sts.blk_oor    = ({1'b0, blk_ff} >= n_blocks);
      sts.has_space  = (n_blocks > reserved);
      sts.div_done   = (div_cnt_ff == 4'(BLK_W));
      sts.start_zero = (rem_ff == '0);
      sts.found      = rd_valid_ff & (|masked);
      sts.phase_done = rd_valid_ff & (rword_ff == last_ff);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_block = rsp_result_ff;
   assign rsp_is_free      = rsp_is_free_ff;

endmodule

/* src/block_bitmap_allocator.sv */
// Query and free: rsp_valid pulses after the request passes dispatch, read and check
// (straight from dispatch on a rejected request). Allocate: setup with a restoring
// remainder division for the search offset, then one bitmap word scanned per cycle
// through the single read port. One transaction at a time; busy is high
// until the result strobe. The receiver cannot stall. After reset a pass over all
// 1024 bitmap words clears the bitmap (all blocks in use) with busy high.
module block_bitmap_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_func,
   input  logic [bba_pkg::BLK_W-1:0] req_block_number,
   input  logic                      csr_wr_en,
   input  logic [bba_pkg::CNT_W-1:0] csr_wr_data,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [bba_pkg::BLK_W-1:0] rsp_result_block,
   output logic                      rsp_is_free
);
   import bba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   bba_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_block_number (req_block_number),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_block (rsp_result_block),
      .rsp_is_free      (rsp_is_free)
   );

endmodule

/* src/bba_checker.sv */
module bba_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [1:0]                rsp_status,
   input logic [bba_pkg::BLK_W-1:0] rsp_result_block,
   input logic                      rsp_is_free
);
   import bba_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_fail_no_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_result_block == '0 && !rsp_is_free))
      else $error("failed transaction returned a block or free flag");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (.*);
